/* design/fibonacci_code_codec_assert.svh */
// assertion macros for the fibonacci code codec
// expects signals clk and rst_n in the including module
`ifndef FIBONACCI_CODE_CODEC_ASSERT_SVH
`define FIBONACCI_CODE_CODEC_ASSERT_SVH

// property checked at every rising clock edge out of reset
`define FCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// same-cycle implication
`define FCC_IMPLY(label, pre, post, msg) \
    `FCC_ASSERT(label, (pre) |-> (post), msg)

`endif

/* design/fcc_pkg.sv */
// shared types, constants and fibonacci term table for the fibonacci code codec
// no dependencies
package fcc_pkg;

    localparam int CODE_BITS_DEF = 64;
    localparam int FIB_TERMS     = 64;
    localparam int VALUE_W       = 44;
    localparam int CODE_W        = 64;
    localparam int LEN_W         = 7;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 44'd17167680177564;

    typedef enum logic
    {
        FCC_ENCODE = 1'b0,
        FCC_DECODE = 1'b1
    } fcc_op_t;

    typedef enum logic
    {
        FCC_IDLE = 1'b0,
        FCC_RUN  = 1'b1
    } fcc_state_t;

    typedef struct packed
    {
        fcc_op_t            op;
        logic [VALUE_W-1:0] value_in;
        logic [CODE_W-1:0]  code_in;
        logic [LEN_W-1:0]   code_len_in;
    } fcc_req_t;

    typedef struct packed
    {
        logic [CODE_W-1:0]  code_out;
        logic [LEN_W-1:0]   code_len_out;
        logic [VALUE_W-1:0] value_out;
        logic               error;
    } fcc_rsp_t;

    typedef struct packed
    {
        logic load;
        logic step;
        logic publish;
    } fcc_cmd_t;

    typedef struct packed
    {
        logic more;
        logic rsp_free;
    } fcc_status_t;

    typedef logic [VALUE_W-1:0] fcc_fib_rom_t [FIB_TERMS];

    // terms 1, 2, 3, 5, ...; the last entry is one above the largest codable value
    function automatic fcc_fib_rom_t build_fib_rom();
        fcc_fib_rom_t rom;
        rom[0] = 44'd1;
        rom[1] = 44'd2;
        for (int i = 2; i < FIB_TERMS; i++)
        begin
            rom[i] = rom[i-1] + rom[i-2];
        end
        return rom;
    endfunction

    localparam fcc_fib_rom_t FIB_ROM = build_fib_rom();

endpackage

/* design/fcc_ctrl.sv */
// controller for the fibonacci code codec: sequences load, term steps and publish
// depends on fcc_pkg
module fcc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  fcc_pkg::fcc_status_t status,
    output fcc_pkg::fcc_cmd_t   cmd
);
    import fcc_pkg::*;

    fcc_state_t state_reg;
    fcc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FCC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FCC_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = FCC_RUN;
                end
            end
            FCC_RUN:
            begin
                if (!status.more && status.rsp_free)
                begin
                    state_next = FCC_IDLE;
                end
            end
            default:
            begin
                state_next = FCC_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            FCC_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            FCC_RUN:
            begin
                cmd.step    = status.more;
                cmd.publish = !status.more && status.rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

/* design/fcc_datapath.sv */
// datapath for the fibonacci code codec: term rom, accumulator, codeword register
// and output register; depends on fcc_pkg and fibonacci_code_codec_assert.svh
`include "fibonacci_code_codec_assert.svh"

module fcc_datapath
#(
    parameter int CODE_BITS = fcc_pkg::CODE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fcc_pkg::fcc_cmd_t    cmd,
    input  fcc_pkg::fcc_req_t    req,
    output fcc_pkg::fcc_status_t status,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output fcc_pkg::fcc_rsp_t    rsp
);
    import fcc_pkg::*;

    localparam int IDX_W = $clog2(CODE_BITS);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CODE_BITS);
    localparam logic [VALUE_W-1:0] ENC_LIMIT = FIB_ROM[CODE_BITS-1];

    typedef logic [IDX_W-1:0] idx_t;

    fcc_op_t              op_reg,    op_next;
    logic                 err_reg,   err_next;
    logic [VALUE_W-1:0]   acc_reg,   acc_next;
    logic [CODE_BITS-1:0] code_reg,  code_next;
    idx_t                 idx_reg,   idx_next;
    idx_t                 cnt_reg,   cnt_next;
    logic [LEN_W-1:0]     len_reg,   len_next;
    logic                 found_reg, found_next;
    fcc_rsp_t             rsp_reg,   rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [VALUE_W-1:0] term;
    logic               fits;
    logic [VALUE_W:0]   sum;
    logic [VALUE_W-1:0] sum_sat;
    idx_t               idx_up;
    logic               enc_err;
    logic               dec_err;

    assign term    = FIB_ROM[6'(idx_reg)];
    assign fits    = term <= acc_reg;
    assign sum     = {1'b0, acc_reg} + {1'b0, term};
    assign sum_sat = (sum > {1'b0, VALUE_MAX}) ? VALUE_MAX : sum[VALUE_W-1:0];
    assign idx_up  = idx_reg + idx_t'(1);

    assign enc_err = (req.value_in == '0) || (req.value_in >= ENC_LIMIT);
    assign dec_err = (req.code_len_in < LEN_W'(2)) || (req.code_len_in > LEN_MAX);

    assign status.more     = cnt_reg != '0;
    assign status.rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        op_next    = op_reg;
        err_next   = err_reg;
        acc_next   = acc_reg;
        code_next  = code_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        found_next = found_reg;
        if (cmd.load)
        begin
            op_next    = req.op;
            code_next  = '0;
            len_next   = '0;
            found_next = 1'b0;
            acc_next   = '0;
            if (req.op == FCC_ENCODE)
            begin
                err_next = enc_err;
                idx_next = idx_t'(CODE_BITS - 2);
                cnt_next = enc_err ? '0 : idx_t'(CODE_BITS - 1);
                if (!enc_err)
                begin
                    acc_next = req.value_in;
                end
            end
            else
            begin
                err_next  = dec_err;
                idx_next  = '0;
                code_next = req.code_in[CODE_BITS-1:0];
                cnt_next  = dec_err ? '0 : idx_t'(req.code_len_in - LEN_W'(1));
            end
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg - idx_t'(1);
            if (op_reg == FCC_ENCODE)
            begin
                idx_next = idx_reg - idx_t'(1);
                if (fits)
                begin
                    acc_next           = acc_reg - term;
                    code_next[idx_reg] = 1'b1;
                    if (!found_reg)
                    begin
                        // first term taken sets the terminator just above it
                        code_next[idx_up] = 1'b1;
                        len_next          = LEN_W'(idx_reg) + LEN_W'(2);
                        found_next        = 1'b1;
                    end
                end
            end
            else
            begin
                idx_next  = idx_up;
                code_next = code_reg >> 1;
                if (code_reg[0])
                begin
                    acc_next = sum_sat;
                end
            end
        end
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (cmd.publish)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            rsp_next.error = err_reg;
            if (!err_reg)
            begin
                if (op_reg == FCC_ENCODE)
                begin
                    rsp_next.code_out     = CODE_W'(code_reg);
                    rsp_next.code_len_out = len_reg;
                end
                else
                begin
                    rsp_next.value_out = acc_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        err_reg   <= err_next;
        acc_reg   <= acc_next;
        code_reg  <= code_next;
        idx_reg   <= idx_next;
        len_reg   <= len_next;
        found_reg <= found_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `FCC_IMPLY(a_step_has_work, cmd.step, cnt_reg != '0, "step issued with no terms left")
    `FCC_IMPLY(a_acc_in_range, cmd.step, acc_reg <= VALUE_MAX, "accumulator out of range")
    `FCC_IMPLY(a_no_adjacent, cmd.step && op_reg == FCC_ENCODE && found_reg && code_reg[idx_up],
        !fits, "encode selected adjacent terms")
    `FCC_IMPLY(a_enc_has_top, cmd.publish && op_reg == FCC_ENCODE && !err_reg,
        found_reg && acc_reg == '0, "encode finished with remainder or no terms")

endmodule

/* design/fibonacci_code_codec.sv */
// Fibonacci (Zeckendorf) code encoder and decoder. An encode walks the term table
// from index CODE_BITS-2 down to 0, one term per cycle; a decode sums one term per
// cycle over the code_len_in-1 positions below the terminator; a rejected request
// (encode of zero or of a value whose codeword is longer than CODE_BITS, decode
// length below two or above CODE_BITS) takes no steps. A result is written to the
// output register once that register is free. The next request is taken in the cycle
// after the result is written. The datapath has a single term rom read and one
// accumulator adder. One item is in work at a time; a finished result sits in an
// output register, so the next item is taken while it waits to be transferred.
// depends on fcc_pkg, fcc_ctrl and fcc_datapath
module fibonacci_code_codec
#(
    parameter int CODE_BITS = fcc_pkg::CODE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  fcc_pkg::fcc_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output fcc_pkg::fcc_rsp_t rsp
);
    import fcc_pkg::*;

    fcc_cmd_t    cmd;
    fcc_status_t status;

    fcc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fcc_datapath #(.CODE_BITS(CODE_BITS)) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// self-checking testbench for fibonacci_code_codec: directed and random encode and decode
// requests from a bursty sender into a stalling receiver, checked against a zeckendorf model
// depends on fcc_pkg and fibonacci_code_codec
module tb_top;
    import fcc_pkg::*;

    localparam int          NUM_TERMS       = 63;
    localparam int          CODEWORD_MAX    = 64;
    localparam logic [63:0] LARGEST_CODABLE = 64'd17167680177564;
    localparam int          RANDOM_ITEMS    = 1400;
    localparam int          DRAIN_CYCLES    = 80;
    localparam int          IDLE_LIMIT      = 2000;
    localparam int          REPORT_MAX      = 40;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    fcc_req_t    req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    fcc_rsp_t    rsp;

    logic [63:0] fib [NUM_TERMS];
    fcc_req_t    requests_to_send [$];
    fcc_rsp_t    answers_due [$];
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          stall_left  = 0;
    int          run_left    = 0;
    int          idle_cycles = 0;
    int unsigned failures    = 0;
    int unsigned reports     = 0;
    int unsigned n_encode    = 0;
    int unsigned n_decode    = 0;
    int unsigned n_checked   = 0;
    int unsigned n_error     = 0;

    fibonacci_code_codec u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic fcc_rsp_t zeckendorf_result(fcc_req_t r);
        fcc_rsp_t    res;
        logic [63:0] n;
        logic [63:0] sum;
        int          top;
        int          len;
        res = '0;
        if (r.op == FCC_ENCODE)
        begin
            n = 64'(r.value_in);
            if (n == 0 || n > LARGEST_CODABLE)
            begin
                res.error = 1'b1;
            end
            else
            begin
                top = 0;
                while (top + 1 < NUM_TERMS && fib[top + 1] <= n)
                    top++;
                for (int i = top; i >= 0; i--)
                begin
                    if (fib[i] <= n)
                    begin
                        res.code_out[i] = 1'b1;
                        n = n - fib[i];
                    end
                end
                res.code_out[top + 1] = 1'b1;
                res.code_len_out      = 7'(top + 2);
            end
        end
        else
        begin
            len = int'(r.code_len_in);
            if (len < 2 || len > CODEWORD_MAX)
            begin
                res.error = 1'b1;
            end
            else
            begin
                sum = '0;
                for (int i = 0; i + 1 < len && i < NUM_TERMS; i++)
                begin
                    if (r.code_in[i])
                        sum = sum + fib[i];
                end
                if (sum > LARGEST_CODABLE)
                    sum = LARGEST_CODABLE;
                res.value_out = sum[43:0];
            end
        end
        return res;
    endfunction

    function automatic fcc_req_t make_item(fcc_op_t op, logic [63:0] value,
                                           logic [63:0] code, int len);
        fcc_req_t r;
        r.op          = op;
        r.value_in    = value[43:0];
        r.code_in     = code;
        r.code_len_in = len[6:0];
        return r;
    endfunction

    function automatic logic [63:0] random_code();
        return {$urandom, $urandom};
    endfunction

    // nonzero and codable, magnitude spread over every width
    function automatic logic [63:0] random_valid_value();
        logic [63:0] v;
        int          w;
        w = $urandom_range(1, 44);
        v = random_code() & ((64'd1 << w) - 1);
        if (v == 0)
            v = 64'd1;
        if (v > LARGEST_CODABLE)
            v = v - LARGEST_CODABLE;
        return v;
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 12);
        return $urandom_range(13, 90);
    endfunction

    task automatic report_mismatch(string field, logic [63:0] want_v, logic [63:0] got_v);
        failures++;
        if (reports < REPORT_MAX)
        begin
            reports++;
            $display("%0t: %s expected %0h got %0h", $time, field, want_v, got_v);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                answers_due.push_back(zeckendorf_result(req));
                if (req.op == FCC_ENCODE)
                    n_encode++;
                else
                    n_decode++;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    req_valid <= 1'b0;
                    gap_left--;
                end
                else if (requests_to_send.size() != 0)
                begin
                    req       <= requests_to_send.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = next_gap();
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        fcc_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    failures++;
                    if (reports < REPORT_MAX)
                    begin
                        reports++;
                        $display("%0t: result transfer with no request waiting, got %h",
                                 $time, rsp);
                    end
                end
                else
                begin
                    want = answers_due.pop_front();
                    n_checked++;
                    if (want.error)
                        n_error++;
                    if (rsp.code_out !== want.code_out)
                        report_mismatch("code_out", want.code_out, rsp.code_out);
                    if (rsp.code_len_out !== want.code_len_out)
                        report_mismatch("code_len_out", 64'(want.code_len_out),
                                        64'(rsp.code_len_out));
                    if (rsp.value_out !== want.value_out)
                        report_mismatch("value_out", 64'(want.value_out), 64'(rsp.value_out));
                    if (rsp.error !== want.error)
                        report_mismatch("error", 64'(want.error), 64'(rsp.error));
                end
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                rsp_stall <= 1'b0;
                run_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                         : $urandom_range(0, 12);
                stall_left = $urandom_range(1, 20);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [63:0] code;
        fcc_rsp_t    enc;
        int          len;
        int          kind;

        fib[0] = 64'd1;
        fib[1] = 64'd2;
        for (int i = 2; i < NUM_TERMS; i++)
            fib[i] = fib[i-1] + fib[i-2];

        // encode corners: zero, small values, top term, largest codable, beyond it
        requests_to_send.push_back(make_item(FCC_ENCODE, 64'd0, random_code(), 5));
        requests_to_send.push_back(make_item(FCC_ENCODE, 64'd1, random_code(), 127));
        requests_to_send.push_back(make_item(FCC_ENCODE, 64'd2, '0, 0));
        requests_to_send.push_back(make_item(FCC_ENCODE, 64'd3, '1, 64));
        requests_to_send.push_back(make_item(FCC_ENCODE, 64'd4, random_code(), 2));
        requests_to_send.push_back(make_item(FCC_ENCODE, 64'd12, random_code(), 1));
        requests_to_send.push_back(make_item(FCC_ENCODE, fib[NUM_TERMS-1], random_code(), 9));
        requests_to_send.push_back(make_item(FCC_ENCODE, LARGEST_CODABLE, random_code(), 64));
        requests_to_send.push_back(make_item(FCC_ENCODE, LARGEST_CODABLE + 1, '0, 0));
        requests_to_send.push_back(make_item(FCC_ENCODE, 64'hFFF_FFFF_FFFF, '1, 127));

        // decode corners: short and long lengths, saturation, junk above the length,
        // missing terminator, adjacent ones
        requests_to_send.push_back(make_item(FCC_DECODE, '1, 64'h1, 0));
        requests_to_send.push_back(make_item(FCC_DECODE, '0, 64'h1, 1));
        requests_to_send.push_back(make_item(FCC_DECODE, random_code(), 64'h3, 2));
        requests_to_send.push_back(make_item(FCC_DECODE, random_code(), 64'h6, 3));
        requests_to_send.push_back(make_item(FCC_DECODE, random_code(), '1, 64));
        enc = zeckendorf_result(make_item(FCC_ENCODE, LARGEST_CODABLE, '0, 0));
        requests_to_send.push_back(make_item(FCC_DECODE, '0, enc.code_out, 64));
        requests_to_send.push_back(make_item(FCC_DECODE, random_code(), 64'hB, 65));
        requests_to_send.push_back(make_item(FCC_DECODE, '1, '1, 127));
        requests_to_send.push_back(make_item(FCC_DECODE, '0, 64'hFFFF_FFFF_FFFF_FFF5, 4));
        requests_to_send.push_back(make_item(FCC_DECODE, random_code(), 64'h5, 5));
        requests_to_send.push_back(make_item(FCC_DECODE, random_code(), 64'hF, 6));

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                requests_to_send.push_back(make_item(FCC_ENCODE, random_valid_value(),
                                                     random_code(), $urandom_range(0, 127)));
            end
            else if (kind < 75)
            begin
                enc  = zeckendorf_result(make_item(FCC_ENCODE, random_valid_value(), '0, 0));
                code = enc.code_out;
                len  = int'(enc.code_len_out);
                if ($urandom_range(0, 2) == 0)
                    code = code | (random_code() << len);
                requests_to_send.push_back(make_item(FCC_DECODE, random_code(), code, len));
            end
            else if (kind < 88)
            begin
                requests_to_send.push_back(make_item(FCC_DECODE, random_code(), random_code(),
                                                     $urandom_range(2, CODEWORD_MAX)));
            end
            else if (kind < 95)
            begin
                len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
                                                  : $urandom_range(CODEWORD_MAX + 1, 127);
                requests_to_send.push_back(make_item(FCC_DECODE, random_code(), random_code(),
                                                     len));
            end
            else
            begin
                code = ($urandom_range(0, 3) == 0) ? 64'd0 : random_code();
                requests_to_send.push_back(make_item(FCC_ENCODE, code, random_code(),
                                                     $urandom_range(0, 127)));
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (requests_to_send.size() != 0 || req_valid || answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d encode and %0d decode transfers under bursty input",
                 n_encode, n_decode);
        $display("%0d results checked, %0d of them error results, %0d mismatches",
                 n_checked, n_error, failures);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
